/* src/bpa_pkg.sv */
// Shared constants, command codes and controller/datapath handshake types.
package bpa_pkg;

  localparam int MAX_PAGE_COUNT_DEF = 65536;
  localparam int WORD_BITS_DEF      = 64;

  localparam int ADDR_W     = 64;
  localparam int CMD_W      = 2;
  localparam int CFG_W      = 17;
  localparam int FREE_W     = 17;
  localparam int OUT_ADDR_W = 28;
  localparam int PAGE_SHIFT = 12;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Page numbers computed from full 64-bit byte addresses, with carry kept.
  localparam int WIDE_PG_W = ADDR_W + 1 - PAGE_SHIFT;

  localparam logic [CMD_W-1:0] CMD_REGION = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

  localparam logic REG_PAGE_LIMIT = 1'b0;
  localparam logic REG_RESERVE    = 1'b1;

  localparam logic [CFG_W-1:0] PAGE_LIMIT_RST = 17'd0;
  localparam logic [CFG_W-1:0] RESERVE_RST    = 17'd1024;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic prep;
    logic clamp;
    logic div;
    logic base;
    logic rd;
    logic modify;
    logic acc;
  } bpa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic walk_done;
  } bpa_sts_t;

endpackage

/* src/bpa_regs.sv */
// Configuration register file behind the APB-style port.
module bpa_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpa_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bpa_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bpa_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [bpa_pkg::CFG_W-1:0]           page_limit,
  output logic [bpa_pkg::CFG_W-1:0]           reserve_pages
);

  logic [bpa_pkg::CFG_W-1:0] page_limit_r, page_limit_nxt;
  logic [bpa_pkg::CFG_W-1:0] reserve_r, reserve_nxt;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Only the word address selects a register; the byte offset is ignored.
  always_comb begin
    page_limit_nxt = page_limit_r;
    reserve_nxt    = reserve_r;
    if (wr_en) begin
      unique case (paddr[2])
        bpa_pkg::REG_PAGE_LIMIT: page_limit_nxt = pwdata[bpa_pkg::CFG_W-1:0];
        bpa_pkg::REG_RESERVE:    reserve_nxt    = pwdata[bpa_pkg::CFG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_limit_r <= bpa_pkg::PAGE_LIMIT_RST;
      reserve_r    <= bpa_pkg::RESERVE_RST;
    end else begin
      page_limit_r <= page_limit_nxt;
      reserve_r    <= reserve_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      bpa_pkg::REG_PAGE_LIMIT: prdata = bpa_pkg::APB_DATA_W'(page_limit_r);
      bpa_pkg::REG_RESERVE:    prdata = bpa_pkg::APB_DATA_W'(reserve_r);
    endcase
  end

  assign page_limit    = page_limit_r;
  assign reserve_pages = reserve_r;

endmodule

/* src/bpa_ctrl.sv */
// Controller state machine that sequences the bitmap datapath.
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output bpa_pkg::bpa_cmd_t cmd_o,
  input  bpa_pkg::bpa_sts_t sts_i
);

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_PREP  = 10'b0000000100,
    S_CLAMP = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_BASE  = 10'b0000100000,
    S_RD    = 10'b0001000000,
    S_MOD   = 10'b0010000000,
    S_TAIL  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (sts_i.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = sts_i.empty ? S_DONE : S_DIV;
      S_DIV:   state_nxt = S_BASE;
      S_BASE:  state_nxt = S_RD;
      S_RD:    state_nxt = S_MOD;
      S_MOD:   state_nxt = sts_i.walk_done ? S_TAIL : S_RD;
      S_TAIL:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_step = (state_r == S_CLR);
    cmd_o.load     = (state_r == S_IDLE) && start;
    cmd_o.prep     = (state_r == S_PREP);
    cmd_o.clamp    = (state_r == S_CLAMP);
    cmd_o.div      = (state_r == S_DIV);
    cmd_o.base     = (state_r == S_BASE);
    cmd_o.rd       = (state_r == S_RD);
    cmd_o.modify   = (state_r == S_MOD);
    // Bit counts of the last modified word are folded into the count in the following RD or TAIL state.
    cmd_o.acc      = (state_r == S_RD) || (state_r == S_TAIL);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

/* src/bpa_datapath.sv */
// Bitmap memory, range arithmetic, word scan and free-page counter.
module bpa_datapath #(
  parameter int MAX_PAGE_COUNT = bpa_pkg::MAX_PAGE_COUNT_DEF,
  parameter int WORD_BITS      = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpa_pkg::bpa_cmd_t                  cmd_i,
  output bpa_pkg::bpa_sts_t                  sts_o,
  input  logic [bpa_pkg::CMD_W-1:0]          in_cmd,
  input  logic [bpa_pkg::ADDR_W-1:0]         in_addr,
  input  logic [bpa_pkg::ADDR_W-1:0]         in_length,
  input  logic [bpa_pkg::CFG_W-1:0]          page_limit,
  input  logic [bpa_pkg::CFG_W-1:0]          reserve_pages,
  output logic [bpa_pkg::OUT_ADDR_W-1:0]     out_page_addr,
  output logic                               out_ok,
  output logic [bpa_pkg::FREE_W-1:0]         out_free_count
);

  localparam int NWORDS   = (MAX_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LIM_W    = $clog2(MAX_PAGE_COUNT + 1);
  localparam int PW       = LIM_W + 1;
  localparam int WB_W     = $clog2(WORD_BITS + 1);
  localparam int K        = PW + $clog2(WORD_BITS);
  localparam int RECIP_W  = K + 1;
  localparam int PROD_W   = PW + RECIP_W;
  localparam int NG       = (WORD_BITS + 7) / 8;
  localparam int WP       = bpa_pkg::WIDE_PG_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << K) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS));
  localparam logic [PW-1:0]   WB_P   = PW'(WORD_BITS);
  localparam logic [WB_W-1:0] WB_C   = WB_W'(WORD_BITS);
  localparam logic [PW-1:0]   MAX_P  = PW'(MAX_PAGE_COUNT);

  logic [WORD_BITS-1:0] mem [NWORDS];

  logic [bpa_pkg::CMD_W-1:0]      cmd_r;
  logic [bpa_pkg::ADDR_W-1:0]     addr_r, len_r;
  logic [WP-1:0]                  first_r, last_r, first_nxt, last_nxt;
  logic [PW-1:0]                  start_r, end_r, base_r;
  logic [IDX_W-1:0]               q_r, idx_r;
  logic [WORD_BITS-1:0]           rd_data_r;
  logic [3:0]                     grp_r [NG];
  logic [bpa_pkg::FREE_W-1:0]     free_r, free_nxt;
  logic                           ok_r;
  logic [bpa_pkg::OUT_ADDR_W-1:0] page_addr_r;

  logic [PW-1:0]              lim;
  logic [WP-1:0]              start_c, end_c;
  logic [bpa_pkg::ADDR_W:0]   sum;
  logic [PROD_W-1:0]          prod;
  logic [WB_W-1:0]            lo, hi;
  logic [PW-1:0]              diff, page;
  logic [WORD_BITS-1:0]       mask, clr_bits, avail, new_word, wr_data;
  logic [3:0]                 grp_sum [NG];
  logic [WB_W-1:0]            cnt;
  logic [WB_W-1:0]            pos;
  logic                       found, is_alloc, last_word, mem_we;

  // Managed limit, clamped to the bitmap size.
  assign lim = (32'(page_limit) > 32'(MAX_PAGE_COUNT)) ? MAX_P : PW'(page_limit);

  // Page range of the command in wide page numbers.
  always_comb begin
    sum       = {1'b0, addr_r} + {1'b0, len_r};
    first_nxt = '1;
    last_nxt  = '0;
    case (cmd_r)
      bpa_pkg::CMD_REGION: begin
        first_nxt = WP'(addr_r[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT])
                  + WP'(|addr_r[bpa_pkg::PAGE_SHIFT-1:0]);
        last_nxt  = sum[bpa_pkg::ADDR_W:bpa_pkg::PAGE_SHIFT];
      end
      bpa_pkg::CMD_ALLOC: begin
        first_nxt = '0;
        last_nxt  = '1;
      end
      bpa_pkg::CMD_FREE: begin
        first_nxt = WP'(addr_r[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT]);
        last_nxt  = WP'(addr_r[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT]) + WP'(1);
      end
      default: begin
        first_nxt = '1;
        last_nxt  = '0;
      end
    endcase
  end

  // The reserved floor applies to region commands only.
  assign start_c = ((cmd_r == bpa_pkg::CMD_REGION) && (first_r < WP'(reserve_pages)))
                 ? WP'(reserve_pages) : first_r;
  assign end_c   = (last_r < WP'(lim)) ? last_r : WP'(lim);

  // Word index of the start page by multiplying with a scaled reciprocal of the word size.
  assign prod = PROD_W'(start_r) * PROD_W'(RECIP);

  // Bits of the current word that fall inside the range.
  always_comb begin
    lo   = (start_r > base_r) ? WB_W'(start_r - base_r) : '0;
    diff = end_r - base_r;
    hi   = (diff >= WB_P) ? WB_C : WB_W'(diff);
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (WB_W'(b) >= lo) && (WB_W'(b) < hi);
    end
  end

  assign is_alloc  = (cmd_r == bpa_pkg::CMD_ALLOC);
  assign clr_bits  = rd_data_r & mask;
  assign avail     = ~rd_data_r & mask;
  assign found     = |avail;
  assign last_word = ((base_r + WB_P) >= end_r);

  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) pos = WB_W'(b);
    end
  end

  assign page     = base_r + PW'(pos);
  assign new_word = is_alloc ? (rd_data_r | (WORD_BITS'(1) << pos)) : (rd_data_r & ~mask);
  assign wr_data  = cmd_i.clr_step ? '1 : new_word;
  assign mem_we   = cmd_i.clr_step | cmd_i.modify;

  // Popcount split into byte groups; groups are summed in the following cycle.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_sum[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (g * 8 + b < WORD_BITS) grp_sum[g] = grp_sum[g] + 4'(clr_bits[g * 8 + b]);
      end
    end
  end

  always_comb begin
    cnt = '0;
    for (int g = 0; g < NG; g++) begin
      cnt = cnt + WB_W'(grp_r[g]);
    end
  end

  always_comb begin
    free_nxt = free_r;
    if (cmd_i.acc) begin
      free_nxt = free_r + bpa_pkg::FREE_W'(cnt);
    end else if (cmd_i.modify && is_alloc && found) begin
      free_nxt = free_r - bpa_pkg::FREE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r] <= wr_data;
    if (cmd_i.rd) rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      free_r <= '0;
    end else begin
      free_r <= free_nxt;
      if (cmd_i.clr_step) begin
        idx_r <= idx_r + IDX_W'(1);
      end else if (cmd_i.base) begin
        idx_r <= q_r;
      end else if (cmd_i.modify && !sts_o.walk_done) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r  <= in_cmd;
      addr_r <= in_addr;
      len_r  <= in_length;
    end
    if (cmd_i.prep) begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
    if (cmd_i.clamp) begin
      start_r     <= PW'(start_c);
      end_r       <= PW'(end_c);
      ok_r        <= (cmd_r == bpa_pkg::CMD_REGION);
      page_addr_r <= '0;
      for (int g = 0; g < NG; g++) grp_r[g] <= '0;
    end
    if (cmd_i.div) begin
      q_r <= IDX_W'(prod >> K);
    end
    if (cmd_i.base) begin
      base_r <= PW'(q_r) * WB_P;
    end
    if (cmd_i.modify) begin
      for (int g = 0; g < NG; g++) grp_r[g] <= is_alloc ? 4'd0 : grp_sum[g];
      if (is_alloc) begin
        if (found) begin
          ok_r        <= 1'b1;
          page_addr_r <= bpa_pkg::OUT_ADDR_W'({page, {bpa_pkg::PAGE_SHIFT{1'b0}}});
        end
      end else if (|clr_bits) begin
        ok_r <= 1'b1;
      end
      if (!sts_o.walk_done) begin
        base_r <= base_r + WB_P;
      end
    end
  end

  always_comb begin
    sts_o.clr_last  = (idx_r == IDX_W'(NWORDS - 1));
    sts_o.empty     = (start_c >= end_c);
    sts_o.walk_done = last_word || (is_alloc && found);
  end

  assign out_page_addr  = page_addr_r;
  assign out_ok         = ok_r;
  assign out_free_count = free_r;

endmodule

/* src/bitmap_page_allocator.sv */
// Top level of the first-fit bitmap page allocator.
//
//  channel   handshake                          payload
//  input     start, busy (accept: start & !busy) in_cmd, in_addr, in_length
//  result    out_valid (one-cycle strobe)        out_page_addr, out_ok, out_free_count
//  config    psel, penable, pwrite, pready       paddr, pwdata, prdata
//
// After reset a clearing pass writes all ones into the bitmap, one word per cycle;
// busy stays high meanwhile.
// A command runs through the accept cycle, range setup in the PREP, CLAMP, DIV and
// BASE states, a read (RD) and a read-modify-write (MOD) state per word on the single
// memory port, then a count update (TAIL) and the result (DONE); busy stays high until
// the result, so no new command is accepted before it. An empty range skips to DONE.
// Allocation scans from word 0 until a free page below the limit is found.
// The result strobe lasts one cycle and cannot be stalled.
module bitmap_page_allocator #(
  parameter int MAX_PAGE_COUNT = bpa_pkg::MAX_PAGE_COUNT_DEF,
  parameter int WORD_BITS      = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bpa_pkg::CMD_W-1:0]          in_cmd,
  input  logic [bpa_pkg::ADDR_W-1:0]         in_addr,
  input  logic [bpa_pkg::ADDR_W-1:0]         in_length,
  output logic                               out_valid,
  output logic [bpa_pkg::OUT_ADDR_W-1:0]     out_page_addr,
  output logic                               out_ok,
  output logic [bpa_pkg::FREE_W-1:0]         out_free_count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bpa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bpa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bpa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  bpa_pkg::bpa_cmd_t         cmd;
  bpa_pkg::bpa_sts_t         sts;
  logic [bpa_pkg::CFG_W-1:0] page_limit;
  logic [bpa_pkg::CFG_W-1:0] reserve_pages;

  bpa_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .page_limit    (page_limit),
    .reserve_pages (reserve_pages)
  );

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  bpa_datapath #(
    .MAX_PAGE_COUNT (MAX_PAGE_COUNT),
    .WORD_BITS      (WORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_cmd         (in_cmd),
    .in_addr        (in_addr),
    .in_length      (in_length),
    .page_limit     (page_limit),
    .reserve_pages  (reserve_pages),
    .out_page_addr  (out_page_addr),
    .out_ok         (out_ok),
    .out_free_count (out_free_count)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a transaction");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_page_addr == '0))
    else $error("failed transaction returned a page address");
`endif

endmodule

/* dv/tb_bitmap_page_allocator.sv */
// Self-checking testbench for the first-fit bitmap page allocator.
module tb_bitmap_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bpa_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int PAGES = bpa_pkg::MAX_PAGE_COUNT_DEF;
  localparam int WORDS = bpa_pkg::MAX_PAGE_COUNT_DEF / bpa_pkg::WORD_BITS_DEF;

  typedef struct packed {
    logic [bpa_pkg::OUT_ADDR_W-1:0] page_addr;
    logic                           ok;
    logic [bpa_pkg::FREE_W-1:0]     free_count;
  } page_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [bpa_pkg::CMD_W-1:0]      in_cmd;
  logic [bpa_pkg::ADDR_W-1:0]     in_addr;
  logic [bpa_pkg::ADDR_W-1:0]     in_length;
  logic                           out_valid;
  logic [bpa_pkg::OUT_ADDR_W-1:0] out_page_addr;
  logic                           out_ok;
  logic [bpa_pkg::FREE_W-1:0]     out_free_count;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bpa_pkg::APB_ADDR_W-1:0] paddr;
  logic [bpa_pkg::APB_DATA_W-1:0] pwdata;
  logic [bpa_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  bitmap_page_allocator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_addr        (in_addr),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_page_addr  (out_page_addr),
    .out_ok         (out_ok),
    .out_free_count (out_free_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Shadow of the allocator state and its registers.
  bit                        page_used [0:PAGES-1];
  int unsigned               pages_free;
  logic [bpa_pkg::CFG_W-1:0] cfg_limit;
  logic [bpa_pkg::CFG_W-1:0] cfg_reserve;

  page_result_t      results_due[$];
  page_result_t      due_head;
  int unsigned       granted_pages[$];
  int unsigned       mismatches;
  int unsigned       n_region, n_alloc, n_alloc_refused, n_free, n_free_refused, n_unknown;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned managed_pages();
    return (cfg_limit > bpa_pkg::CFG_W'(PAGES)) ? PAGES : int'(cfg_limit);
  endfunction

  // Applies one command to the shadow bitmap and returns the result it should produce.
  function automatic page_result_t compute_page_result(
      input logic [bpa_pkg::CMD_W-1:0]  cmd,
      input logic [bpa_pkg::ADDR_W-1:0] addr,
      input logic [bpa_pkg::ADDR_W-1:0] len);
    page_result_t              r;
    logic [bpa_pkg::ADDR_W:0]  span_end;
    logic [52:0]               first_pg;
    logic [52:0]               end_pg;
    longint unsigned           p;
    int unsigned               lim;
    r = '0;
    lim = managed_pages();
    case (cmd)
      bpa_pkg::CMD_REGION: begin
        n_region++;
        // Round the start up to a page and the end down; the carry past 2^64 is kept.
        first_pg = 53'(addr >> bpa_pkg::PAGE_SHIFT)
                 + 53'(addr[bpa_pkg::PAGE_SHIFT-1:0] != '0);
        span_end = {1'b0, addr} + {1'b0, len};
        end_pg = 53'(span_end >> bpa_pkg::PAGE_SHIFT);
        if (first_pg < 53'(cfg_reserve)) first_pg = 53'(cfg_reserve);
        if (end_pg > 53'(lim)) end_pg = 53'(lim);
        for (p = first_pg; p < end_pg; p++) begin
          if (page_used[p[15:0]]) begin
            page_used[p[15:0]] = 1'b0;
            pages_free++;
          end
        end
        r.ok = 1'b1;
      end
      bpa_pkg::CMD_ALLOC: begin
        n_alloc++;
        for (p = 0; p < lim; p++) begin
          if (!page_used[p[15:0]]) begin
            page_used[p[15:0]] = 1'b1;
            pages_free--;
            r.page_addr = bpa_pkg::OUT_ADDR_W'(p << bpa_pkg::PAGE_SHIFT);
            r.ok = 1'b1;
            granted_pages.push_back(int'(p));
            break;
          end
        end
        if (!r.ok) n_alloc_refused++;
      end
      bpa_pkg::CMD_FREE: begin
        n_free++;
        p = addr >> bpa_pkg::PAGE_SHIFT;
        if (p < lim && page_used[p[15:0]]) begin
          page_used[p[15:0]] = 1'b0;
          pages_free++;
          r.ok = 1'b1;
        end else begin
          n_free_refused++;
        end
      end
      default: n_unknown++;
    endcase
    r.free_count = bpa_pkg::FREE_W'(pages_free);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        note_mismatch("unexpected result page_addr", '0, 64'(out_page_addr));
      end else begin
        due_head = results_due.pop_front();
        if (out_page_addr !== due_head.page_addr)
          note_mismatch("page_addr", 64'(due_head.page_addr), 64'(out_page_addr));
        if (out_ok !== due_head.ok)
          note_mismatch("ok", 64'(due_head.ok), 64'(out_ok));
        if (out_free_count !== due_head.free_count)
          note_mismatch("free_count", 64'(due_head.free_count), 64'(out_free_count));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic issue(input logic [bpa_pkg::CMD_W-1:0]  cmd,
                       input logic [bpa_pkg::ADDR_W-1:0] addr,
                       input logic [bpa_pkg::ADDR_W-1:0] len);
    start = 1'b1;
    in_cmd = cmd;
    in_addr = addr;
    in_length = len;
    @(posedge clk);
    while (busy) @(posedge clk);
    results_due.push_back(compute_page_result(cmd, addr, len));
    @(negedge clk);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_for_results();
    start = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes a register, then reads it back.
  task automatic program_reg(input logic reg_sel,
                             input logic [bpa_pkg::APB_DATA_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_sel, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == bpa_pkg::REG_RESERVE) cfg_reserve = value[bpa_pkg::CFG_W-1:0];
    else cfg_limit = value[bpa_pkg::CFG_W-1:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== bpa_pkg::APB_DATA_W'(value[bpa_pkg::CFG_W-1:0]))
      note_mismatch("register read back", 64'(value[bpa_pkg::CFG_W-1:0]), 64'(prdata));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_after_reset();
    // Nothing is managed while page_limit is still zero.
    issue(bpa_pkg::CMD_ALLOC, '0, '0);
    issue(bpa_pkg::CMD_REGION, '0, '1);
    issue(bpa_pkg::CMD_FREE, 64'h5000, '0);
    issue(CMD_UNKNOWN, '1, '1);
  endtask

  task automatic test_region_trimming();
    wait_for_results();
    program_reg(bpa_pkg::REG_PAGE_LIMIT, 32'd2048);
    program_reg(bpa_pkg::REG_RESERVE, 32'd1024);
    issue(bpa_pkg::CMD_REGION, 64'h40_0001, 64'h3000);    // partial pages at both ends
    issue(bpa_pkg::CMD_REGION, 64'h3F_F000, 64'h2000);    // starts inside the reserved pages
    issue(bpa_pkg::CMD_REGION, 64'h50_0800, 64'h400);     // inside one page, nothing whole
    issue(bpa_pkg::CMD_REGION, 64'h60_0000, '0);
    // The end address wraps past 2^64, so the region runs to the limit.
    issue(bpa_pkg::CMD_REGION, 64'h44_C010, 64'hFFFF_FFFF_FFFF_F000);
  endtask

  task automatic test_alloc_and_free();
    issue(bpa_pkg::CMD_ALLOC, '0, '0);
    issue(bpa_pkg::CMD_ALLOC, '0, '0);
    issue(bpa_pkg::CMD_FREE, 64'h40_0FFF, '0);
    issue(bpa_pkg::CMD_FREE, 64'h40_0000, '0);            // already free
    issue(bpa_pkg::CMD_FREE, 64'hBB_8000, '0);            // above the limit
    issue(bpa_pkg::CMD_FREE, 64'hA000, '0);               // reserved but used page
    issue(bpa_pkg::CMD_ALLOC, '0, '0);
  endtask

  task automatic test_full_range();
    wait_for_results();
    program_reg(bpa_pkg::REG_PAGE_LIMIT, 32'hFFFF_FFFF);  // clamps to the maximum page count
    program_reg(bpa_pkg::REG_RESERVE, 32'd0);
    issue(bpa_pkg::CMD_REGION, '0, '1);
    issue(bpa_pkg::CMD_ALLOC, '0, '0);
  endtask

  task automatic test_small_limit();
    wait_for_results();
    program_reg(bpa_pkg::REG_PAGE_LIMIT, 32'd64);
    program_reg(bpa_pkg::REG_RESERVE, 32'd65536);
    issue(bpa_pkg::CMD_REGION, '0, 64'h10_0000);
    issue(bpa_pkg::CMD_ALLOC, '0, '0);
    issue(bpa_pkg::CMD_FREE, 64'h6_4000, '0);
    issue(bpa_pkg::CMD_FREE, '1, '0);
    wait_for_results();
    // Free pages remain above the limit, yet the only managed page is taken.
    program_reg(bpa_pkg::REG_PAGE_LIMIT, 32'd1);
    issue(bpa_pkg::CMD_ALLOC, '0, '0);
  endtask

  task automatic test_random_mix(input int unsigned count, input int unsigned idle_pct);
    int unsigned                lim_now;
    int unsigned                kind;
    int unsigned                pick;
    longint unsigned            pg;
    logic [bpa_pkg::CMD_W-1:0]  cmd;
    logic [bpa_pkg::ADDR_W-1:0] addr;
    logic [bpa_pkg::ADDR_W-1:0] len;
    lim_now = managed_pages();
    for (int n = 0; n < count; n++) begin
      if (n == count / 4 || $urandom_range(0, 99) == 0)
        wait_for_results();
      else if ((n % 64) < 48 && $urandom_range(1, 100) <= idle_pct)
        hold_off($urandom_range(1, 12));
      kind = $urandom_range(0, 99);
      len = '0;
      if (kind < 35) begin
        cmd = bpa_pkg::CMD_ALLOC;
        addr = {$urandom, $urandom};
      end else if (kind < 65) begin
        cmd = bpa_pkg::CMD_FREE;
        if (granted_pages.size() != 0 && $urandom_range(0, 1)) begin
          pick = $urandom_range(0, granted_pages.size() - 1);
          pg = granted_pages[pick];
          granted_pages.delete(pick);
        end else begin
          pg = $urandom_range(0, lim_now + 32);
        end
        addr = (64'(pg) << bpa_pkg::PAGE_SHIFT) | 64'($urandom_range(0, 4095));
      end else if (kind < 94) begin
        cmd = bpa_pkg::CMD_REGION;
        pg = $urandom_range(0, lim_now + 64);
        addr = 64'(pg) << bpa_pkg::PAGE_SHIFT;
        if ($urandom_range(0, 3) != 0) addr |= 64'($urandom_range(0, 4095));
        len = 64'($urandom_range(0, 80)) << bpa_pkg::PAGE_SHIFT;
        if ($urandom_range(0, 1)) len |= 64'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) == 0) len = {$urandom, $urandom};
      end else begin
        // Noise: any code with arbitrary wide operands.
        cmd = bpa_pkg::CMD_W'($urandom_range(0, 3));
        addr = {$urandom, $urandom};
        len = {$urandom, $urandom};
      end
      issue(cmd, addr, len);
    end
    wait_for_results();
  endtask

  initial begin
    logic [bpa_pkg::CFG_W-1:0] small_lim;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    in_addr = '0;
    in_length = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    pages_free = 0;
    cfg_limit = bpa_pkg::PAGE_LIMIT_RST;
    cfg_reserve = bpa_pkg::RESERVE_RST;
    foreach (page_used[i]) page_used[i] = 1'b1;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_region_trimming();
    test_alloc_and_free();
    test_full_range();
    test_small_limit();

    wait_for_results();
    program_reg(bpa_pkg::REG_PAGE_LIMIT, 32'd4096);
    program_reg(bpa_pkg::REG_RESERVE, 32'd1024);
    test_random_mix(225, 6);

    // Small pool so that allocations run dry; upper write bits carry junk.
    small_lim = bpa_pkg::CFG_W'($urandom_range(48, 200));
    program_reg(bpa_pkg::REG_PAGE_LIMIT, {$urandom} & ~32'h1FFFF | 32'(small_lim));
    program_reg(bpa_pkg::REG_RESERVE,
                {$urandom} & ~32'h1FFFF | $urandom_range(0, small_lim));
    test_random_mix(225, 82);

    program_reg(bpa_pkg::REG_PAGE_LIMIT, 32'd65536);
    program_reg(bpa_pkg::REG_RESERVE, 32'd1024);
    test_random_mix(225, 0);

    wait_for_results();
    repeat (2 * WORDS + 40) @(negedge clk);
    $display("Checked %0d region, %0d allocate (%0d refused), %0d page free (%0d refused)",
             n_region, n_alloc, n_alloc_refused, n_free, n_free_refused);
    $display("and %0d undefined-code transactions over limits from 0 up to the clamp.",
             n_unknown);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
